### sv/bqv_pkg.sv
`timescale 1ns / 1ps
package bqv_pkg;

    localparam int ONE_Q16       = 65536;
    localparam int COORD_W_DEF   = 32;
    localparam int POS_W         = 32;
    localparam int OFF_W         = 48;
    localparam int VEC_W         = 16;
    localparam int PROD_W        = 64;
    localparam int ACC_W         = 50;
    localparam int UV_W          = 17;
    localparam int TEX_W         = 15;
    localparam int LANES         = 4;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [3:0] {
        CFG_RIGHT_X = 4'd0,
        CFG_RIGHT_Y = 4'd1,
        CFG_RIGHT_Z = 4'd2,
        CFG_UP_X    = 4'd3,
        CFG_UP_Y    = 4'd4,
        CFG_UP_Z    = 4'd5,
        CFG_TEX_W   = 4'd6,
        CFG_TEX_H   = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [OFF_W-1:0] off_r0;
        logic signed [OFF_W-1:0] off_r1;
        logic signed [OFF_W-1:0] off_u0;
        logic signed [OFF_W-1:0] off_u1;
        logic [UV_W-1:0]         u0;
        logic [UV_W-1:0]         u1;
        logic [UV_W-1:0]         v0;
        logic [UV_W-1:0]         v1;
    } bqv_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } bqv_vec_t;

endpackage

### sv/billboard_quad_vertex_generator.sv
`timescale 1ns / 1ps
// channel   | handshake                 | beat contents
// ----------+---------------------------+---------------------------------------
// sprite in | in_valid / in_ready       | pos, size, pivot, frame rectangle
// corner out| out_valid / out_ready     | vert xyz, tex uv, corner, last
// config    | cfg_we (no wait)          | cfg_index, cfg_data
//
// The back end emits one corner beat per cycle while a sprite is waiting and out_ready holds.
// A sprite passes the 17-step UV divider pipeline in the front end, then the queue,
// then the multiply and sum stages in the back end.
// Reset clears all valid flags and loads the default camera vectors.
// Either side may stall; a 4-entry queue decouples front and back.
module billboard_quad_vertex_generator
    import bqv_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] size_w,
    input  logic signed [31:0] size_h,
    input  logic [16:0]        pivot_x,
    input  logic [16:0]        pivot_y,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic signed [15:0] rect_w,
    input  logic signed [15:0] rect_h,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic signed [31:0] vert_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [1:0]         corner,
    output logic               last
);

    bqv_vec_t          right_reg, up_reg;
    logic [TEX_W-1:0]  texw_reg, texh_reg;
    logic              fq_valid;
    logic              fq_ready;
    bqv_item_t         fq_item, qb_item;
    logic              qb_valid, qb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg <= '{x: 16'sd16384, y: 16'sd0, z: 16'sd0};
            up_reg    <= '{x: 16'sd0, y: 16'sd16384, z: 16'sd0};
            texw_reg  <= '0;
            texh_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RIGHT_X: right_reg.x <= cfg_data;
                CFG_RIGHT_Y: right_reg.y <= cfg_data;
                CFG_RIGHT_Z: right_reg.z <= cfg_data;
                CFG_UP_X:    up_reg.x    <= cfg_data;
                CFG_UP_Y:    up_reg.y    <= cfg_data;
                CFG_UP_Z:    up_reg.z    <= cfg_data;
                CFG_TEX_W:   texw_reg    <= cfg_data[TEX_W-1:0];
                CFG_TEX_H:   texh_reg    <= cfg_data[TEX_W-1:0];
                default:     ;
            endcase
        end
    end

    bqv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .size_w   (size_w),
        .size_h   (size_h),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .rect_x   (rect_x),
        .rect_y   (rect_y),
        .rect_w   (rect_w),
        .rect_h   (rect_h),
        .tex_w    (texw_reg),
        .tex_h    (texh_reg),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    bqv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    bqv_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .right     (right_reg),
        .up        (up_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .vert_z    (vert_z),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .corner    (corner),
        .last      (last)
    );

endmodule

### sv/bqv_front.sv
`timescale 1ns / 1ps
module bqv_front
    import bqv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      pos_x,
    input  logic signed [31:0]      pos_y,
    input  logic signed [31:0]      pos_z,
    input  logic signed [31:0]      size_w,
    input  logic signed [31:0]      size_h,
    input  logic [16:0]             pivot_x,
    input  logic [16:0]             pivot_y,
    input  logic signed [15:0]      rect_x,
    input  logic signed [15:0]      rect_y,
    input  logic signed [15:0]      rect_w,
    input  logic signed [15:0]      rect_h,
    input  logic [TEX_W-1:0]        tex_w,
    input  logic [TEX_W-1:0]        tex_h,
    output logic                    q_valid,
    input  logic                    q_ready,
    output bqv_item_t               q_item
);

    localparam int NSTG = UV_W;

    function automatic logic [31:0] frame_edges(
        input logic signed [15:0] org,
        input logic signed [15:0] len,
        input logic [TEX_W-1:0]   t
    );
        logic signed [17:0] o;
        logic signed [17:0] l;
        logic signed [17:0] ts;
        logic signed [17:0] hi;
        ts = signed'({3'b000, t});
        o  = {{2{org[15]}}, org};
        l  = {{2{len[15]}}, len};
        if (o < 18'sd0)
            o = 18'sd0;
        if (o >= ts)
            o = ts - 18'sd1;
        if (l <= 18'sd0)
            l = ts;
        if (l > ts - o)
            l = ts - o;
        hi = o + l;
        return {o[15:0], hi[15:0]};
    endfunction

    logic                    vld_reg [0:NSTG];
    logic                    full_reg [0:NSTG];
    logic [15:0]             rem_reg [0:NSTG][LANES];
    logic [UV_W-1:0]         quo_reg [0:NSTG][LANES];
    logic [TEX_W-1:0]        div_reg [0:NSTG][LANES];
    bqv_item_t               itm_reg [1:NSTG];

    logic signed [31:0]      px_reg, py_reg, pz_reg;
    logic [30:0]             sw_reg, sh_reg;
    logic [16:0]             kx_reg, ky_reg;

    logic [15:0]             rem_next [0:NSTG-1][LANES];
    logic [UV_W-1:0]         quo_next [0:NSTG-1][LANES];
    bqv_item_t               itm_next;

    logic                    en;
    logic [31:0]             edge_x, edge_y;
    logic [30:0]             sw_eff, sh_eff;
    logic [16:0]             kx_eff, ky_eff;
    logic [OFF_W-1:0]        pr_r0, pr_r1, pr_u0, pr_u1;

    assign en       = !vld_reg[NSTG] || q_ready;
    assign in_ready = en;

    assign edge_x = frame_edges(rect_x, rect_w, tex_w);
    assign edge_y = frame_edges(rect_y, rect_h, tex_h);
    assign sw_eff = (size_w > 32'sd0) ? size_w[30:0] : 31'(ONE_Q16);
    assign sh_eff = (size_h > 32'sd0) ? size_h[30:0] : 31'(ONE_Q16);
    assign kx_eff = (pivot_x > 17'(ONE_Q16)) ? 17'(ONE_Q16) : pivot_x;
    assign ky_eff = (pivot_y > 17'(ONE_Q16)) ? 17'(ONE_Q16) : pivot_y;

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [16:0] cand;
                cand = (k == 0) ? {1'b0, rem_reg[k][l]} : {rem_reg[k][l], 1'b0};
                if (cand >= {2'b00, div_reg[k][l]})
                begin
                    rem_next[k][l] = 16'(cand - {2'b00, div_reg[k][l]});
                    quo_next[k][l] = {quo_reg[k][l][UV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = cand[15:0];
                    quo_next[k][l] = {quo_reg[k][l][UV_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        pr_r0 = 48'(sw_reg) * 48'(kx_reg);
        pr_r1 = 48'(sw_reg) * 48'(17'(ONE_Q16) - kx_reg);
        pr_u0 = 48'(sh_reg) * 48'(ky_reg);
        pr_u1 = 48'(sh_reg) * 48'(17'(ONE_Q16) - ky_reg);
        itm_next        = '0;
        itm_next.pos_x  = px_reg;
        itm_next.pos_y  = py_reg;
        itm_next.pos_z  = pz_reg;
        itm_next.off_r0 = -signed'(pr_r0);
        itm_next.off_r1 = signed'(pr_r1);
        itm_next.off_u0 = -signed'(pr_u0);
        itm_next.off_u1 = signed'(pr_u1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= NSTG; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            sw_reg <= sw_eff;
            sh_reg <= sh_eff;
            kx_reg <= kx_eff;
            ky_reg <= ky_eff;
            full_reg[0]   <= (tex_w == '0) || (tex_h == '0);
            rem_reg[0][0] <= edge_x[31:16];
            rem_reg[0][1] <= edge_x[15:0];
            rem_reg[0][2] <= edge_y[31:16];
            rem_reg[0][3] <= edge_y[15:0];
            div_reg[0][0] <= tex_w;
            div_reg[0][1] <= tex_w;
            div_reg[0][2] <= tex_h;
            div_reg[0][3] <= tex_h;
            for (int l = 0; l < LANES; l++)
                quo_reg[0][l] <= '0;
            itm_reg[1] <= itm_next;
            for (int k = 2; k <= NSTG; k++)
                itm_reg[k] <= itm_reg[k-1];
            for (int k = 1; k <= NSTG; k++)
            begin
                full_reg[k] <= full_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k-1][l];
                    quo_reg[k][l] <= quo_next[k-1][l];
                    div_reg[k][l] <= div_reg[k-1][l];
                end
            end
        end
    end

    always_comb
    begin
        q_item = itm_reg[NSTG];
        if (full_reg[NSTG])
        begin
            q_item.u0 = '0;
            q_item.u1 = UV_W'(ONE_Q16);
            q_item.v0 = '0;
            q_item.v1 = UV_W'(ONE_Q16);
        end
        else
        begin
            q_item.u0 = quo_reg[NSTG][0];
            q_item.u1 = quo_reg[NSTG][1];
            q_item.v0 = quo_reg[NSTG][2];
            q_item.v1 = quo_reg[NSTG][3];
        end
    end

    assign q_valid = vld_reg[NSTG];

endmodule

### sv/bqv_queue.sv
`timescale 1ns / 1ps
module bqv_queue
    import bqv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  bqv_item_t  push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output bqv_item_t  pop_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    bqv_item_t       mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign push_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

### sv/bqv_back.sv
`timescale 1ns / 1ps
module bqv_back
    import bqv_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  bqv_item_t          q_item,
    input  bqv_vec_t           right,
    input  bqv_vec_t           up,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic signed [31:0] vert_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [1:0]         corner,
    output logic               last
);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        (ACC_W'(1) <<< (COORD_WIDTH-1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [1:0]                 cnt_reg;
    logic                       va_reg;
    logic signed [PROD_W-1:0]   pr_reg [3];
    logic signed [PROD_W-1:0]   pu_reg [3];
    logic signed [POS_W-1:0]    pos_reg [3];
    logic [UV_W-1:0]            u_reg, v_reg;
    logic [1:0]                 c_reg;

    logic                       out_valid_reg;
    logic signed [31:0]         vx_reg, vy_reg, vz_reg;
    logic [UV_W-1:0]            tu_reg, tv_reg;
    logic [1:0]                 co_reg;

    logic                       en, sr, su;
    logic signed [OFF_W-1:0]    offr, offu;
    logic signed [ACC_W-1:0]    crd_next [3];

    assign en      = !out_valid_reg || out_ready;
    assign q_ready = en && (cnt_reg == 2'd3);
    assign sr      = (cnt_reg == 2'd1) || (cnt_reg == 2'd2);
    assign su      = cnt_reg[1];
    assign offr    = sr ? q_item.off_r1 : q_item.off_r0;
    assign offu    = su ? q_item.off_u1 : q_item.off_u0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [PROD_W-1:0] sum;
            logic signed [ACC_W-1:0]  v;
            sum = pr_reg[i] + pu_reg[i];
            v   = ACC_W'(pos_reg[i]) + ACC_W'($signed(sum[PROD_W-1:30]));
            if (v > SAT_HI)
                crd_next[i] = SAT_HI;
            else if (v < SAT_LO)
                crd_next[i] = SAT_LO;
            else
                crd_next[i] = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            va_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= q_valid;
            out_valid_reg <= va_reg;
            if (q_valid)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0]  <= offr * right.x;
            pr_reg[1]  <= offr * right.y;
            pr_reg[2]  <= offr * right.z;
            pu_reg[0]  <= offu * up.x;
            pu_reg[1]  <= offu * up.y;
            pu_reg[2]  <= offu * up.z;
            pos_reg[0] <= q_item.pos_x;
            pos_reg[1] <= q_item.pos_y;
            pos_reg[2] <= q_item.pos_z;
            u_reg      <= sr ? q_item.u1 : q_item.u0;
            v_reg      <= su ? q_item.v0 : q_item.v1;
            c_reg      <= cnt_reg;
            vx_reg     <= crd_next[0][31:0];
            vy_reg     <= crd_next[1][31:0];
            vz_reg     <= crd_next[2][31:0];
            tu_reg     <= u_reg;
            tv_reg     <= v_reg;
            co_reg     <= c_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign vert_x    = vx_reg;
    assign vert_y    = vy_reg;
    assign vert_z    = vz_reg;
    assign tex_u     = tu_reg;
    assign tex_v     = tv_reg;
    assign corner    = co_reg;
    assign last      = (co_reg == 2'd3);

endmodule

### sv/bqv_checker.sv
`timescale 1ns / 1ps
module bqv_checker
    import bqv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] vert_x,
    input  logic [16:0]        tex_u,
    input  logic [16:0]        tex_v,
    input  logic [1:0]         corner,
    input  logic               last
);

    a_last_on_corner3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (corner == 2'd3)))
        else $error("last flag does not match corner index");

    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((tex_u <= 17'(ONE_Q16)) && (tex_v <= 17'(ONE_Q16))))
        else $error("uv above one");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(vert_x) && $stable(corner)))
        else $error("output beat changed while stalled");

endmodule

bind billboard_quad_vertex_generator bqv_checker u_bqv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vert_x    (vert_x),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .corner    (corner),
    .last      (last)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bqv_pkg::*;

    typedef struct {
        logic signed [31:0] px, py, pz, sw, sh;
        logic [16:0]        kx, ky;
        logic signed [15:0] rx, ry, rw, rh;
    } sprite_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [16:0]        u, v;
        logic [1:0]         c;
        logic               l;
    } corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, size_w = '0, size_h = '0;
    logic [16:0] pivot_x = '0, pivot_y = '0;
    logic signed [15:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] vert_x, vert_y, vert_z;
    logic [16:0] tex_u, tex_v;
    logic [1:0] corner;
    logic last;

    billboard_quad_vertex_generator u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic signed [15:0] vec_r [3];
    logic signed [15:0] vec_u [3];
    logic [14:0] tex_w, tex_h;

    sprite_t pending_sprites [$];
    corner_t expected_corners [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH %s at %0t", what, $realtime);
        errors++;
    endtask

    function automatic logic signed [31:0] place_coord(input longint pos, input longint offr,
                                                       input longint vr, input longint offu,
                                                       input longint vu);
        longint s, q, v;
        s = offr * vr + offu * vu;
        q = s >>> 30;
        v = pos + q;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic frame_edges(input logic signed [15:0] org, input logic signed [15:0] len,
                               input longint tex, output logic [16:0] lo,
                               output logic [16:0] hi);
        longint o, l;
        o = org;
        l = len;
        if (o < 0)
            o = 0;
        if (o >= tex)
            o = tex - 1;
        if (l <= 0)
            l = tex;
        if (l > tex - o)
            l = tex - o;
        lo = 17'((o * 65536) / tex);
        hi = 17'(((o + l) * 65536) / tex);
    endtask

    task automatic predict_quad(input sprite_t s);
        longint sw, sh, kx, ky;
        longint offr [2];
        longint offu [2];
        logic [16:0] u0, u1, v0, v1;
        corner_t e;
        int sr, su;
        sw = (s.sw > 0) ? longint'(s.sw) : 65536;
        sh = (s.sh > 0) ? longint'(s.sh) : 65536;
        kx = (s.kx > 65536) ? 65536 : s.kx;
        ky = (s.ky > 65536) ? 65536 : s.ky;
        offr[0] = -(sw * kx);
        offr[1] = sw * (65536 - kx);
        offu[0] = -(sh * ky);
        offu[1] = sh * (65536 - ky);
        u0 = 0; u1 = 65536; v0 = 0; v1 = 65536;
        if (tex_w > 0 && tex_h > 0)
        begin
            frame_edges(s.rx, s.rw, tex_w, u0, u1);
            frame_edges(s.ry, s.rh, tex_h, v0, v1);
        end
        for (int c = 0; c < 4; c++)
        begin
            sr = (c == 1 || c == 2);
            su = (c >= 2);
            e.x = place_coord(s.px, offr[sr], vec_r[0], offu[su], vec_u[0]);
            e.y = place_coord(s.py, offr[sr], vec_r[1], offu[su], vec_u[1]);
            e.z = place_coord(s.pz, offr[sr], vec_r[2], offu[su], vec_u[2]);
            e.u = sr ? u1 : u0;
            e.v = su ? v0 : v1;
            e.c = 2'(c);
            e.l = (c == 3);
            expected_corners.push_back(e);
        end
    endtask

    // driver
    logic in_ready_seen = 1'b0;
    sprite_t cur;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_quad(cur);
        in_ready_seen <= rst_n && in_valid && in_ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (pending_sprites.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur = pending_sprites.pop_front();
                    pos_x <= cur.px; pos_y <= cur.py; pos_z <= cur.pz;
                    size_w <= cur.sw; size_h <= cur.sh;
                    pivot_x <= cur.kx; pivot_y <= cur.ky;
                    rect_x <= cur.rx; rect_y <= cur.ry; rect_w <= cur.rw; rect_h <= cur.rh;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        corner_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_corners.size() == 0)
                report_mismatch("unexpected corner beat");
            else
            begin
                e = expected_corners.pop_front();
                if (vert_x !== e.x) report_mismatch($sformatf("vert_x %h exp %h", vert_x, e.x));
                if (vert_y !== e.y) report_mismatch($sformatf("vert_y %h exp %h", vert_y, e.y));
                if (vert_z !== e.z) report_mismatch($sformatf("vert_z %h exp %h", vert_z, e.z));
                if (tex_u !== e.u) report_mismatch($sformatf("tex_u %h exp %h", tex_u, e.u));
                if (tex_v !== e.v) report_mismatch($sformatf("tex_v %h exp %h", tex_v, e.v));
                if (corner !== e.c) report_mismatch($sformatf("corner %0d exp %0d", corner, e.c));
                if (last !== e.l) report_mismatch($sformatf("last %b exp %b", last, e.l));
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RIGHT_X: vec_r[0] = val;
            CFG_RIGHT_Y: vec_r[1] = val;
            CFG_RIGHT_Z: vec_r[2] = val;
            CFG_UP_X:    vec_u[0] = val;
            CFG_UP_Y:    vec_u[1] = val;
            CFG_UP_Z:    vec_u[2] = val;
            CFG_TEX_W:   tex_w = val[14:0];
            CFG_TEX_H:   tex_h = val[14:0];
            default: ;
        endcase
    endtask

    task automatic write_unused(input logic [3:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_sprites.size() > 0 || in_valid || expected_corners.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick32;
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] pick16;
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(20) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sprite_t random_sprite;
        sprite_t s;
        s.px = pick32(); s.py = pick32(); s.pz = pick32();
        s.sw = ($urandom_range(3) == 0) ? pick32() : $urandom_range(32'h00400000);
        s.sh = ($urandom_range(3) == 0) ? pick32() : $urandom_range(32'h00400000);
        s.kx = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        s.ky = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        s.rx = pick16(); s.ry = pick16(); s.rw = pick16(); s.rh = pick16();
        return s;
    endfunction

    task automatic add_sprite(input logic signed [31:0] p, input logic signed [31:0] sz,
                              input logic [16:0] k, input logic signed [15:0] r,
                              input logic signed [15:0] l);
        sprite_t s;
        s.px = p; s.py = -p; s.pz = p ^ 32'h5a5a5a5a;
        s.sw = sz; s.sh = sz;
        s.kx = k; s.ky = 17'(65536) - ((k > 65536) ? 17'd65536 : k);
        s.rx = r; s.ry = r; s.rw = l; s.rh = l;
        pending_sprites.push_back(s);
    endtask

    initial
    begin
        int idle_set [4] = '{0, 58, 0, 35};
        int stall_set [4] = '{0, 0, 58, 35};
        vec_r = '{16'sd16384, 16'sd0, 16'sd0};
        vec_u = '{16'sd0, 16'sd16384, 16'sd0};
        tex_w = 0;
        tex_h = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unknown texture at reset defaults
        add_sprite(32'sh00010000, 32'sh00020000, 17'd32768, 16'sd0, 16'sd0);
        add_sprite(32'sh7fffffff, 32'sh7fffffff, 17'd0, -16'sd5, -16'sd1);
        wait_drained();

        write_reg(CFG_TEX_W, 16'd64);
        write_reg(CFG_TEX_H, 16'd16384);
        write_unused(4'd8, 16'h1234);
        write_unused(4'd15, 16'hffff);
        add_sprite(32'sh80000000, 32'sh00000000, 17'd65536, -16'sd7, 16'sd10);
        add_sprite(32'sh00000000, -32'sh1, 17'h1ffff, 16'sd63, 16'sd0);
        add_sprite(32'sh12345678, 32'sh7fffffff, 17'd65537, 16'sh7fff, 16'sh7fff);
        add_sprite(-32'sh12345678, 32'sh80000000, 17'd1, 16'sh8000, 16'sh8000);
        add_sprite(32'sh00008000, 32'sh00000001, 17'd32768, 16'sd10, 16'sd100);
        add_sprite(32'sh7fff0000, 32'sh00100000, 17'd16384, 16'sd20, 16'sd20);
        wait_drained();

        write_reg(CFG_RIGHT_X, 16'sh7fff);
        write_reg(CFG_RIGHT_Y, 16'sh8000);
        write_reg(CFG_RIGHT_Z, 16'sh7fff);
        write_reg(CFG_UP_X, 16'sh8000);
        write_reg(CFG_UP_Y, 16'sh7fff);
        write_reg(CFG_UP_Z, 16'sh8000);
        write_reg(CFG_TEX_W, 16'd1);
        write_reg(CFG_TEX_H, 16'd3);
        add_sprite(32'sh7fffffff, 32'sh7fffffff, 17'd0, 16'sd0, 16'sd0);
        add_sprite(32'sh80000000, 32'sh7fffffff, 17'd65536, 16'sd5, 16'sd2);
        add_sprite(32'sh00000000, 32'sh00010000, 17'd32768, -16'sd1, 16'sd1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int i = 0; i < 8; i++)
                if ($urandom_range(1))
                    write_reg(cfg_idx_t'(i), (i >= 6) ? 16'($urandom_range(16384)) : 16'($urandom));
            if (ph == 2)
            begin
                write_reg(CFG_TEX_W, 16'd16384);
                write_reg(CFG_TEX_H, 16'd0);
            end
            for (int i = 0; i < 100; i++)
            begin
                pending_sprites.push_back(random_sprite());
                if (i == 50)
                begin
                    while (pending_sprites.size() > 0 || in_valid) @(posedge clk);
                    while (expected_corners.size() > 0) @(posedge clk);
                end
            end
            wait_drained();
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
